FILE: sv/tcc_pkg.sv
package tcc_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CELL_W = 16;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
    localparam logic [COL_W-1:0]  COL_END    = COL_W'(COLS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_END    = ROW_W'(ROWS);
    localparam logic [ADDR_W-1:0] ADDR_ROW   = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] ADDR_CELLS = ADDR_W'(NCELLS);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(NCELLS - 1);
    localparam logic [ADDR_W-1:0] ADDR_COPY_LAST = ADDR_W'(NCELLS - COLS - 1);

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic put;
        logic rd_cell;
        logic cap_data;
        logic scr_rd;
        logic scr_wr;
        logic fill;
        logic fill_zero;
        logic addr_clr;
        logic load_out;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       put_scroll;
        logic       addr_copy_last;
        logic       addr_last;
        logic       out_free;
    } t_stat;

endpackage

FILE: sv/tcc_ram.sv
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tcc_ctrl.sv
module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_ctl  o_ctl,
    output logic  o_in_stall
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_RD,
        ST_RD_WT,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_FILL,
        ST_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_ctl.fill      = 1'b1;
                o_ctl.fill_zero = 1'b1;
                if (i_stat.addr_last) begin
                    o_ctl.addr_clr = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    unique case (i_stat.cmd)
                        CMD_PUT:   n_state = ST_PUT;
                        CMD_CLEAR: n_state = ST_FILL;
                        CMD_READ:  n_state = ST_RD;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_PUT: begin
                o_ctl.put = 1'b1;
                n_state   = i_stat.put_scroll ? ST_SCR_RD : ST_DONE;
            end
            ST_RD: begin
                o_ctl.rd_cell = 1'b1;
                n_state       = ST_RD_WT;
            end
            ST_RD_WT: begin
                o_ctl.cap_data = 1'b1;
                n_state        = ST_DONE;
            end
            ST_SCR_RD: begin
                o_ctl.scr_rd = 1'b1;
                n_state      = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                o_ctl.scr_wr = 1'b1;
                n_state      = i_stat.addr_copy_last ? ST_FILL : ST_SCR_RD;
            end
            ST_FILL: begin
                o_ctl.fill = 1'b1;
                if (i_stat.addr_last) begin
                    o_ctl.addr_clr = 1'b1;
                    n_state        = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: sv/tcc_dp.sv
module tcc_dp
    import tcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  logic      i_out_stall,
    input  t_ctl      i_ctl,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    t_in_item          r_item;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_addr;
    logic [CELL_W-1:0] r_data;
    logic              r_scrolled;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [ADDR_W-1:0] lin;
    logic              is_nl, is_bs;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic              put_scroll;
    logic              put_we;
    logic [ADDR_W-1:0] put_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    assign lin   = ADDR_W'(r_row * ADDR_ROW) + ADDR_W'(r_col);
    assign is_nl = (r_item.char_code == CH_NEWLINE);
    assign is_bs = (r_item.char_code == CH_BACKSPACE);

    // cursor after a put; backspace lands on lin-1, even across rows, but does nothing at row 0, col 0
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        put_scroll = 1'b0;
        put_we     = 1'b0;
        put_addr   = lin;
        if (is_nl) begin
            n_col = '0;
            n_row = r_row + 1'b1;
        end else if (is_bs) begin
            put_addr = lin - 1'b1;
            if (r_col != '0) begin
                n_col  = r_col - 1'b1;
                put_we = 1'b1;
            end else if (r_row != '0) begin
                n_col  = COL_LAST;
                n_row  = r_row - 1'b1;
                put_we = 1'b1;
            end
        end else begin
            n_col  = r_col + 1'b1;
            put_we = 1'b1;
        end
        if (n_col >= COL_END) begin
            n_col = '0;
            n_row = n_row + 1'b1;
        end
        if (n_row >= ROW_END) begin
            n_col      = '0;
            n_row      = ROW_LAST;
            put_scroll = 1'b1;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {r_item.color, CH_BLANK};
        if (i_ctl.put) begin
            ram_we    = put_we;
            ram_waddr = put_addr;
            ram_wdata = {r_item.color, is_bs ? CH_BLANK : r_item.char_code};
        end else if (i_ctl.scr_wr) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end else if (i_ctl.fill) begin
            ram_we = 1'b1;
            if (i_ctl.fill_zero) begin
                ram_wdata = '0;
            end
        end
    end

    // scroll reads the cell one row below the one being written
    assign ram_raddr = i_ctl.rd_cell ? r_item.cell_index :
                       (i_ctl.scr_rd ? r_addr + ADDR_ROW : r_addr);

    tcc_ram #(
        .WIDTH(CELL_W),
        .DEPTH(NCELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.accept && i_in_data.cmd == CMD_CLEAR) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_ctl.put) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_ctl.addr_clr) begin
                r_addr <= '0;
            end else if (i_ctl.scr_wr || i_ctl.fill) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_item     <= i_in_data;
            r_data     <= '0;
            r_scrolled <= 1'b0;
        end
        if (i_ctl.put) begin
            r_scrolled <= put_scroll;
        end
        if (i_ctl.cap_data) begin
            r_data <= (r_item.cell_index < ADDR_CELLS) ? ram_rdata : '0;
        end
        if (i_ctl.load_out) begin
            r_out.cursor_col <= r_col;
            r_out.cursor_row <= r_row;
            r_out.cell_data  <= r_data;
            r_out.scrolled   <= r_scrolled;
        end
    end

    assign o_stat.cmd            = i_in_data.cmd;
    assign o_stat.put_scroll     = put_scroll;
    assign o_stat.addr_copy_last = (r_addr == ADDR_COPY_LAST);
    assign o_stat.addr_last      = (r_addr == ADDR_LAST);
    assign o_stat.out_free       = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/text_console_cursor_scroll.sv
// Put: ST_IDLE, ST_PUT, ST_DONE; no new item is taken before the result is
// loaded. Cmd 3: ST_IDLE, ST_DONE. Read cell: ST_RD, ST_RD_WT, ST_DONE
// (registered RAM read). Clear: 2000 cells, one cell write per cycle. Scrolling
// put: 1920 cells move up a row, each read in ST_SCR_RD and written in
// ST_SCR_WR, then the last 80 are blanked. After reset the screen RAM is zeroed
// one cell per cycle with o_in_stall high; cursor and control state clear at once.
module text_console_cursor_scroll
    import tcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_ctl  ctl;
    t_stat stat;

    tcc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (stat),
        .o_ctl     (ctl),
        .o_in_stall(o_in_stall)
    );

    tcc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_out_stall(i_out_stall),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule

FILE: sv/tcc_checker.sv
module tcc_checker
    import tcc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cursor_col < COL_END)
                     && (o_out_data.cursor_row < ROW_END))
        else $error("cursor out of screen");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.scrolled |->
            o_out_data.cursor_col == '0 && o_out_data.cursor_row == ROW_LAST)
        else $error("scroll left cursor off the last row start");

    a_scroll_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.scrolled |-> o_out_data.cell_data == '0)
        else $error("scroll beat carries cell data");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again without a busy cycle");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (.*);
